>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check, ignored while reset is asserted.
`define BTD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define BTD_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    `BTD_ASSERT(label, clk, rstn, !(expr), msg)

`endif

>>> hw/rtl/btd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package btd_pkg;

    typedef enum logic [2:0] {
        PH_IDENT   = 3'd0,
        PH_LEN     = 3'd1,
        PH_LONGLEN = 3'd2,
        PH_CONTENT = 3'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_INT    = 3'd1,
        KIND_OID    = 3'd2,
        KIND_RAW    = 3'd3,
        KIND_ERR    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_HIGH_TAG = 2'd1,
        ERR_LEN_FORM = 2'd2,
        ERR_INT_LEN  = 2'd3
    } err_t;

    localparam logic [7:0] TAG_INTEGER    = 8'h02;
    localparam logic [7:0] TAG_OID        = 8'h06;
    localparam logic [7:0] TAG_COUNTER32  = 8'h41;
    localparam logic [7:0] TAG_GAUGE32    = 8'h42;
    localparam logic [7:0] TAG_TIMETICKS  = 8'h43;
    localparam logic [7:0] TAG_COUNTER64  = 8'h46;
    localparam logic [7:0] TAG_UINTEGER32 = 8'h47;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tag;
        logic [63:0] value;
        logic [2:0]  header_size;
        err_t        error_code;
        logic        element_end;
        logic        last_result;
    } result_t;

    // Results produced by one byte: count is 0, 1 or 2; r0 goes out first.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

`default_nettype wire

>>> hw/rtl/btd_step.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module btd_step (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_in_byte,
    input  wire logic          s_restart,
    input  wire logic          room,
    output btd_pkg::push_t     push
);
    import btd_pkg::*;

    function automatic logic is_int32(input logic [7:0] t);
        begin
            is_int32 = (t == TAG_INTEGER) || (t == TAG_COUNTER32) || (t == TAG_GAUGE32) ||
                       (t == TAG_TIMETICKS) || (t == TAG_UINTEGER32);
        end
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] t,
                                            input logic [63:0] v, input logic [2:0] hs,
                                            input err_t e, input logic last_of_elem);
        result_t r;
        begin
            r.kind        = k;
            r.tag         = t;
            r.value       = v;
            r.header_size = hs;
            r.error_code  = e;
            r.element_end = last_of_elem;
            r.last_result = 1'b0;
            make_result   = r;
        end
    endfunction

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        restart_reg;
    logic        advance;

    // Parser state
    phase_t      phase_reg,  phase_next;
    logic [7:0]  tag_reg,    tag_next;
    logic [2:0]  lol_reg,    lol_next;
    logic [31:0] la_reg,     la_next;
    logic [31:0] cl_reg,     cl_next;
    logic [2:0]  hc_reg,     hc_next;
    logic [63:0] va_reg,     va_next;
    logic        fco_reg,    fco_next;
    logic        skip_reg,   skip_next;

    // Shared decode
    phase_t      ph;
    logic [7:0]  b;
    logic [2:0]  hc_inc;
    logic [31:0] la_shift;
    logic [2:0]  lol_dec;
    logic [31:0] cl_dec;
    logic        cont_last;
    logic        cnt_ok;
    logic        short_len;
    logic        long_done;
    logic        hdr_done;
    logic [31:0] hdr_len;
    logic        tag_int;
    logic        tag_c64;
    logic        hdr_bad;
    logic [63:0] num_mask;
    logic [63:0] num_acc0;
    logic [63:0] num_val;
    logic [63:0] oid_acc;
    logic [15:0] div_prod;
    logic [2:0]  oid_q;
    logic [7:0]  oid_r;
    logic [1:0]  n_res;
    result_t     r0;
    result_t     r1;

    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            restart_reg <= s_restart;
        end
    end

    assign ph        = restart_reg ? PH_IDENT : phase_reg;
    assign b         = in_byte_reg;
    assign hc_inc    = hc_reg + 3'd1;
    assign la_shift  = {la_reg[23:0], b};
    assign lol_dec   = lol_reg - 3'd1;
    assign cl_dec    = cl_reg - 32'd1;
    assign cont_last = (cl_dec == 32'd0);
    assign cnt_ok    = (b[6:3] == 4'd0) && (b[2:0] != 3'd0) && (b[2:0] <= 3'd4);
    assign short_len = (ph == PH_LEN) && !b[7];
    assign long_done = (ph == PH_LONGLEN) && (lol_dec == 3'd0);
    assign hdr_done  = short_len || long_done;
    assign hdr_len   = short_len ? {24'd0, b} : la_shift;
    assign tag_int   = is_int32(tag_reg);
    assign tag_c64   = (tag_reg == TAG_COUNTER64);
    assign hdr_bad   = (tag_int && ((hdr_len == 32'd0) || (hdr_len > 32'd5))) ||
                       (tag_c64 && ((hdr_len == 32'd0) || (hdr_len > 32'd9)));

    // Integer content: sign fill on the first octet, then shift in
    assign num_mask = tag_c64 ? {64{1'b1}} : {32'd0, {32{1'b1}}};
    assign num_acc0 = fco_reg ? (b[7] ? num_mask : 64'd0) : va_reg;
    assign num_val  = {num_acc0[55:0], b} & num_mask;
    assign oid_acc  = {32'd0, va_reg[24:0], b[6:0]};

    // First OID octet: divide by 40 via reciprocal 205/8192 (exact for 8 bits)
    assign div_prod = {8'd0, b} * 16'd205;
    assign oid_q    = div_prod[15:13];
    assign oid_r    = b - ({oid_q, 5'd0} + {2'd0, oid_q, 3'd0});

    // Results
    always_comb begin
        n_res = 2'd0;
        r0    = make_result(KIND_HEADER, tag_reg, 64'd0, 3'd0, ERR_NONE, 1'b0);
        r1    = r0;
        case (ph)
            PH_LEN, PH_LONGLEN: begin
                if (hdr_done) begin
                    r0 = make_result(KIND_HEADER, tag_reg, {32'd0, hdr_len}, hc_inc,
                                     ERR_NONE, !hdr_bad && (hdr_len == 32'd0));
                    r1 = make_result(KIND_ERR, tag_reg, 64'd0, hc_inc, ERR_INT_LEN, 1'b1);
                    n_res = hdr_bad ? 2'd2 : 2'd1;
                end else if ((ph == PH_LEN) && !cnt_ok) begin
                    r0 = make_result(KIND_ERR, tag_reg, 64'd0, hc_inc, ERR_LEN_FORM, 1'b1);
                    n_res = 2'd1;
                end
            end
            PH_CONTENT: begin
                if (skip_reg) begin
                    n_res = 2'd0;
                end else if (tag_int || tag_c64) begin
                    r0 = make_result(KIND_INT, tag_reg, num_val, 3'd0, ERR_NONE, 1'b1);
                    n_res = cont_last ? 2'd1 : 2'd0;
                end else if (tag_reg == TAG_OID) begin
                    if (fco_reg) begin
                        r0 = make_result(KIND_OID, tag_reg, {61'd0, oid_q}, 3'd0,
                                         ERR_NONE, 1'b0);
                        r1 = make_result(KIND_OID, tag_reg, {56'd0, oid_r}, 3'd0,
                                         ERR_NONE, cont_last);
                        n_res = 2'd2;
                    end else begin
                        r0 = make_result(KIND_OID, tag_reg, oid_acc, 3'd0, ERR_NONE,
                                         cont_last);
                        n_res = b[7] ? 2'd0 : 2'd1;
                    end
                end else begin
                    r0 = make_result(KIND_RAW, tag_reg, {56'd0, b}, 3'd0, ERR_NONE,
                                     cont_last);
                    n_res = 2'd1;
                end
            end
            default: begin
                if (b[4:0] == 5'h1F) begin
                    r0 = make_result(KIND_ERR, b, 64'd0, 3'd0, ERR_HIGH_TAG, 1'b1);
                    n_res = 2'd1;
                end
            end
        endcase
        r0.last_result = (n_res == 2'd1);
        r1.last_result = 1'b1;
        push.count = advance ? n_res : 2'd0;
        push.r0    = r0;
        push.r1    = r1;
    end

    // Next state
    always_comb begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        lol_next   = lol_reg;
        la_next    = la_reg;
        cl_next    = cl_reg;
        hc_next    = hc_reg;
        va_next    = va_reg;
        fco_next   = fco_reg;
        skip_next  = skip_reg;
        case (ph)
            PH_LEN, PH_LONGLEN: begin
                hc_next = hc_inc;
                if (ph == PH_LONGLEN) begin
                    la_next  = la_shift;
                    lol_next = lol_dec;
                end
                if (hdr_done) begin
                    fco_next   = 1'b1;
                    va_next    = 64'd0;
                    cl_next    = hdr_len;
                    lol_next   = 3'd0;
                    skip_next  = hdr_bad;
                    phase_next = (hdr_len == 32'd0) ? PH_IDENT : PH_CONTENT;
                end else if (ph == PH_LEN) begin
                    if (cnt_ok) begin
                        lol_next   = b[2:0];
                        la_next    = 32'd0;
                        phase_next = PH_LONGLEN;
                    end else begin
                        phase_next = PH_IDENT;
                    end
                end
            end
            PH_CONTENT: begin
                cl_next = cl_dec;
                if (!skip_reg) begin
                    if (tag_int || tag_c64) begin
                        va_next = num_val;
                    end else if (tag_reg == TAG_OID) begin
                        if (fco_reg || !b[7]) begin
                            va_next = 64'd0;
                        end else begin
                            va_next = oid_acc;
                        end
                    end
                end
                fco_next = 1'b0;
                if (cont_last) begin
                    phase_next = PH_IDENT;
                    skip_next  = 1'b0;
                end
            end
            default: begin
                if (b[4:0] == 5'h1F) begin
                    phase_next = PH_IDENT;
                end else begin
                    tag_next   = b;
                    hc_next    = 3'd1;
                    lol_next   = 3'd0;
                    la_next    = 32'd0;
                    cl_next    = 32'd0;
                    va_next    = 64'd0;
                    fco_next   = 1'b1;
                    skip_next  = 1'b0;
                    phase_next = PH_LEN;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDENT;
            tag_reg   <= 8'd0;
            lol_reg   <= 3'd0;
            la_reg    <= 32'd0;
            cl_reg    <= 32'd0;
            hc_reg    <= 3'd0;
            va_reg    <= 64'd0;
            fco_reg   <= 1'b1;
            skip_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            lol_reg   <= lol_next;
            la_reg    <= la_next;
            cl_reg    <= cl_next;
            hc_reg    <= hc_next;
            va_reg    <= va_next;
            fco_reg   <= fco_next;
            skip_reg  <= skip_next;
        end
    end

    `BTD_ASSERT(a_pair_last, aclk, aresetn, (push.count == 2'd2) |-> (push.r1.last_result && !push.r0.last_result), "pair has wrong last_result marks")
    `BTD_ASSERT(a_pair_kind, aclk, aresetn, (push.count == 2'd2) |-> ((push.r0.kind == KIND_HEADER && push.r1.kind == KIND_ERR) || (push.r0.kind == KIND_OID && push.r1.kind == KIND_OID)), "unexpected result pair")
    `BTD_ASSERT(a_restart_phase, aclk, aresetn, (advance && restart_reg) |=> (phase_reg == PH_LEN || phase_reg == PH_IDENT), "restart byte not taken as identifier")

endmodule

`default_nettype wire

>>> hw/rtl/btd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module btd_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire btd_pkg::push_t   push,
    output logic                  room,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output btd_pkg::result_t      m_result
);
    import btd_pkg::*;

    // Three-entry shift queue; e0 is the entry on the output port.
    result_t    e0_reg, e0_next;
    result_t    e1_reg, e1_next;
    result_t    e2_reg, e2_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] cnt_a;
    logic       pop;

    always_comb begin
        pop     = (cnt_reg != 2'd0) && m_ready;
        e0_next = pop ? e1_reg : e0_reg;
        e1_next = pop ? e2_reg : e1_reg;
        e2_next = e2_reg;
        cnt_a   = cnt_reg - {1'b0, pop};
        if (push.count != 2'd0) begin
            case (cnt_a)
                2'd0: begin
                    e0_next = push.r0;
                    if (push.count == 2'd2) begin
                        e1_next = push.r1;
                    end
                end
                2'd1: begin
                    e1_next = push.r0;
                    if (push.count == 2'd2) begin
                        e2_next = push.r1;
                    end
                end
                default: begin
                    e2_next = push.r0;
                end
            endcase
        end
        cnt_next = cnt_a + push.count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
        e2_reg <= e2_next;
    end

    // Room for a worst-case pair even if nothing drains this cycle
    assign room     = (cnt_reg <= 2'd1);
    assign m_valid  = (cnt_reg != 2'd0);
    assign m_result = e0_reg;

    `BTD_ASSERT(a_push_room, aclk, aresetn, (push.count != 2'd0) |-> (cnt_reg <= 2'd1), "push into a full queue")
    `BTD_ASSERT_NEVER(a_push_count, aclk, aresetn, push.count == 2'd3, "more than two results from one byte")
    `BTD_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_result)), "stalled result changed")

endmodule

`default_nettype wire

>>> hw/rtl/ber_tlv_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming decoder for SNMP-style BER elements, one byte per transaction.
// Each byte is registered, decoded combinationally against the parser state and
// its zero, one or two results are written into a three-entry output queue;
// results leave it on m_* in the order in which they were written.
// The block takes one byte per clock as long as the queue holds at most one
// result, so a stream whose bytes make at most one result each runs at one
// byte per cycle with m_ready high. A byte that makes two results (a header
// with its bad-length error, or the first OID octet) leaves two results in
// the queue, so the next byte is held back until one drains. restart forces
// the byte to be read as an identifier octet and drops any element underway.
// Errors come out as results of kind 4; there are no configuration registers.
module ber_tlv_stream_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_restart,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_kind,
    output logic [7:0]       m_tag,
    output logic [63:0]      m_value,
    output logic [2:0]       m_header_size,
    output logic [1:0]       m_error_code,
    output logic             m_element_end,
    output logic             m_last_result
);
    import btd_pkg::*;

    push_t   push;
    logic    room;
    result_t m_result;

    btd_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_restart (s_restart),
        .room      (room),
        .push      (push)
    );

    btd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_kind        = m_result.kind;
    assign m_tag         = m_result.tag;
    assign m_value       = m_result.value;
    assign m_header_size = m_result.header_size;
    assign m_error_code  = m_result.error_code;
    assign m_element_end = m_result.element_end;
    assign m_last_result = m_result.last_result;

endmodule

`default_nettype wire

>>> sim/ber_tlv_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the BER decoder, predicts the results of every
// accepted byte and compares them in order with what the block delivers.
module ber_tlv_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_restart,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_kind,
    input  logic [7:0]  m_tag,
    input  logic [63:0] m_value,
    input  logic [2:0]  m_header_size,
    input  logic [1:0]  m_error_code,
    input  logic        m_element_end,
    input  logic        m_last_result,
    output int          mismatches,
    output int          pending,
    output int          results_checked,
    output int          error_results
);

    import btd_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;

    result_t expected_results[$];
    result_t byte_results[$];

    // parser state mirrored from the block
    phase_t      ph;
    logic [7:0]  cur_tag;
    logic [2:0]  len_left;
    logic [31:0] len_acc;
    logic [31:0] content_left;
    logic [2:0]  hdr_cnt;
    logic [63:0] num_acc;
    logic        first_oct;
    logic        skip_content;

    function automatic logic is_int32_tag(input logic [7:0] t);
        return t == TAG_INTEGER || t == TAG_COUNTER32 || t == TAG_GAUGE32 ||
               t == TAG_TIMETICKS || t == TAG_UINTEGER32;
    endfunction

    task automatic reset_parser();
        ph = PH_IDENT;
        cur_tag = '0;
        len_left = '0;
        len_acc = '0;
        content_left = '0;
        hdr_cnt = '0;
        num_acc = '0;
        first_oct = 1'b1;
        skip_content = 1'b0;
    endtask

    task automatic add_result(input kind_t k, input logic [7:0] t, input logic [63:0] v,
                              input logic [2:0] hs, input err_t e, input logic closes);
        result_t r;
        r.kind = k;
        r.tag = t;
        r.value = v;
        r.header_size = hs;
        r.error_code = e;
        r.element_end = closes;
        r.last_result = 1'b0;
        byte_results.push_back(r);
    endtask

    // length known: header, plus an error when an integer type has a bad length
    task automatic open_content(input logic [31:0] len);
        logic bad;
        bad = 1'b0;
        if (is_int32_tag(cur_tag))
            bad = (len < 1 || len > 5);
        else if (cur_tag == TAG_COUNTER64)
            bad = (len < 1 || len > 9);
        first_oct = 1'b1;
        num_acc = '0;
        content_left = len;
        len_left = '0;
        if (bad) begin
            add_result(KIND_HEADER, cur_tag, {32'd0, len}, hdr_cnt, ERR_NONE, 1'b0);
            add_result(KIND_ERR, cur_tag, 64'd0, hdr_cnt, ERR_INT_LEN, 1'b1);
            skip_content = 1'b1;
        end else begin
            add_result(KIND_HEADER, cur_tag, {32'd0, len}, hdr_cnt, ERR_NONE, len == 0);
            skip_content = 1'b0;
        end
        ph = (len == 0) ? PH_IDENT : PH_CONTENT;
    endtask

    task automatic content_byte(input logic [7:0] b);
        logic        last;
        logic [63:0] mask;
        content_left = content_left - 1;
        last = (content_left == 0);
        if (skip_content) begin
            // swallowed after a bad integer length
        end else if (is_int32_tag(cur_tag) || cur_tag == TAG_COUNTER64) begin
            mask = (cur_tag == TAG_COUNTER64) ? '1 : MASK32;
            if (first_oct)
                num_acc = b[7] ? mask : 64'd0;
            num_acc = ((num_acc << 8) | {56'd0, b}) & mask;
            if (last)
                add_result(KIND_INT, cur_tag, num_acc, 3'd0, ERR_NONE, 1'b1);
        end else if (cur_tag == TAG_OID) begin
            if (first_oct) begin
                add_result(KIND_OID, cur_tag, 64'(b / 40), 3'd0, ERR_NONE, 1'b0);
                add_result(KIND_OID, cur_tag, 64'(b % 40), 3'd0, ERR_NONE, last);
                num_acc = '0;
            end else begin
                num_acc = ((num_acc << 7) | {57'd0, b[6:0]}) & MASK32;
                // a subidentifier still open at the element end is dropped
                if (!b[7]) begin
                    add_result(KIND_OID, cur_tag, num_acc, 3'd0, ERR_NONE, last);
                    num_acc = '0;
                end
            end
        end else begin
            add_result(KIND_RAW, cur_tag, {56'd0, b}, 3'd0, ERR_NONE, last);
        end
        first_oct = 1'b0;
        if (last) begin
            ph = PH_IDENT;
            skip_content = 1'b0;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic restart);
        phase_t  cur_ph;
        result_t r;
        byte_results.delete();
        cur_ph = restart ? PH_IDENT : ph;
        case (cur_ph)
            PH_LEN: begin
                hdr_cnt = hdr_cnt + 3'd1;
                if (!b[7]) begin
                    open_content({24'd0, b});
                end else if (b[6:0] >= 1 && b[6:0] <= 4) begin
                    len_left = b[2:0];
                    len_acc = '0;
                    ph = PH_LONGLEN;
                end else begin
                    add_result(KIND_ERR, cur_tag, 64'd0, hdr_cnt, ERR_LEN_FORM, 1'b1);
                    ph = PH_IDENT;
                end
            end
            PH_LONGLEN: begin
                hdr_cnt = hdr_cnt + 3'd1;
                len_acc = {len_acc[23:0], b};
                len_left = len_left - 3'd1;
                if (len_left == 0)
                    open_content(len_acc);
            end
            PH_CONTENT: content_byte(b);
            default: begin
                if (b[4:0] == 5'h1F) begin
                    add_result(KIND_ERR, b, 64'd0, 3'd0, ERR_HIGH_TAG, 1'b1);
                    ph = PH_IDENT;
                end else begin
                    cur_tag = b;
                    hdr_cnt = 3'd1;
                    len_left = '0;
                    len_acc = '0;
                    content_left = '0;
                    num_acc = '0;
                    first_oct = 1'b1;
                    skip_content = 1'b0;
                    ph = PH_LEN;
                end
            end
        endcase
        if (byte_results.size() > 0) begin
            r = byte_results.pop_back();
            r.last_result = 1'b1;
            byte_results.push_back(r);
        end
        foreach (byte_results[i])
            expected_results.push_back(byte_results[i]);
    endtask

    task automatic check_result();
        result_t got;
        result_t want;
        got.kind = kind_t'(m_kind);
        got.tag = m_tag;
        got.value = m_value;
        got.header_size = m_header_size;
        got.error_code = err_t'(m_error_code);
        got.element_end = m_element_end;
        got.last_result = m_last_result;
        results_checked++;
        if (got.kind == KIND_ERR)
            error_results++;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] unexpected result: kind=%0d tag=%h value=%h", $time,
                         m_kind, m_tag, m_value);
        end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.tag !== want.tag || got.value !== want.value ||
                got.header_size !== want.header_size ||
                got.error_code !== want.error_code ||
                got.element_end !== want.element_end ||
                got.last_result !== want.last_result) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] mismatch exp: kind=%0d tag=%h value=%h hsize=%0d err=%0d end=%0b last=%0b",
                             $time, want.kind, want.tag, want.value, want.header_size,
                             want.error_code, want.element_end, want.last_result);
                    $display("[%0t]          got: kind=%0d tag=%h value=%h hsize=%0d err=%0d end=%0b last=%0b",
                             $time, m_kind, m_tag, m_value, m_header_size, m_error_code,
                             m_element_end, m_last_result);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_parser();
            expected_results.delete();
            pending = 0;
        end else begin
            if (s_valid && s_ready)
                decode_byte(s_in_byte, s_restart);
            if (m_valid && m_ready)
                check_result();
            pending = expected_results.size();
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    import btd_pkg::*;

    localparam int N_BYTES        = 400;
    localparam int N_DIRECTED     = 26;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    // hand-picked stream: high tag, Counter64 sign extension, zero-length
    // integer, both bad length forms, OID ending mid-subidentifier, empty
    // element, long-form length, and a restart cutting off an INTEGER
    localparam logic [7:0] DIRECTED [N_DIRECTED] = '{
        8'hFF,
        8'h46, 8'h01, 8'h80,
        8'h41, 8'h00,
        8'h30, 8'h80,
        8'h04, 8'h85,
        8'h06, 8'h02, 8'h2B, 8'h86,
        8'h05, 8'h00,
        8'h04, 8'h81, 8'h01, 8'h7F,
        8'h02, 8'h02, 8'h01,
        8'h43, 8'h01, 8'h05
    };
    localparam int DIRECTED_RESTART_AT = 23;

    typedef struct packed {
        logic [7:0] data;
        logic       restart;
    } stim_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'd0;
    logic        s_restart = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [7:0]  m_tag;
    logic [63:0] m_value;
    logic [2:0]  m_header_size;
    logic [1:0]  m_error_code;
    logic        m_element_end;
    logic        m_last_result;

    int mismatches;
    int pending;
    int results_checked;
    int error_results;

    stim_t byte_stream[$];
    int    bytes_sent = 0;
    int    restarts_sent = 0;
    int    quiet_cycles = 0;
    bit    restart_next = 0;

    always #1 aclk = ~aclk;

    ber_tlv_stream_decoder DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_tag        (m_tag),
        .m_value      (m_value),
        .m_header_size(m_header_size),
        .m_error_code (m_error_code),
        .m_element_end(m_element_end),
        .m_last_result(m_last_result)
    );

    ber_tlv_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_tag          (m_tag),
        .m_value        (m_value),
        .m_header_size  (m_header_size),
        .m_error_code   (m_error_code),
        .m_element_end  (m_element_end),
        .m_last_result  (m_last_result),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_checked(results_checked),
        .error_results  (error_results)
    );

    task automatic push_byte(input logic [7:0] b, input logic r);
        stim_t item;
        item.data = b;
        item.restart = r;
        byte_stream.push_back(item);
    endtask

    // One random BER element, mostly well formed, sometimes cut short or noise.
    task automatic gen_element();
        logic [7:0] el[$];
        logic [7:0] tag;
        logic [7:0] b;
        int         sel, len, nlen, k, keep;
        bit         first_restart, is_oid, well_formed;
        sel = $urandom_range(0, 99);
        first_restart = restart_next || ($urandom_range(0, 99) < 15);
        restart_next = 0;
        is_oid = 0;
        well_formed = 0;
        tag = 8'($urandom_range(0, 255));
        if (tag[4:0] == 5'h1F)
            tag[0] = 1'b0;
        len = $urandom_range(0, 6);
        if (sel < 78) begin
            well_formed = 1;
            if (sel < 28) begin
                case ($urandom_range(0, 4))
                    0: tag = TAG_INTEGER;
                    1: tag = TAG_COUNTER32;
                    2: tag = TAG_GAUGE32;
                    3: tag = TAG_TIMETICKS;
                    default: tag = TAG_UINTEGER32;
                endcase
                if ($urandom_range(0, 99) < 85) begin
                    len = $urandom_range(1, 5);
                end else begin
                    k = $urandom_range(0, 3);
                    len = (k == 0) ? 0 : k + 5;
                end
            end else if (sel < 40) begin
                tag = TAG_COUNTER64;
                if ($urandom_range(0, 99) < 85) begin
                    len = $urandom_range(1, 9);
                end else begin
                    k = $urandom_range(0, 2);
                    len = (k == 0) ? 0 : k + 9;
                end
            end else if (sel < 58) begin
                tag = TAG_OID;
                is_oid = 1;
                len = $urandom_range(1, 8);
            end
            el.push_back(tag);
            if ($urandom_range(0, 99) < 25) begin
                // long form, padded with leading zero octets when nlen > 1
                nlen = $urandom_range(1, 4);
                el.push_back(8'h80 | 8'(nlen));
                for (k = nlen - 1; k >= 0; k--)
                    el.push_back(8'(len >> (8 * k)));
            end else begin
                el.push_back(8'(len));
            end
            for (k = 0; k < len; k++) begin
                b = 8'($urandom_range(0, 255));
                if (is_oid && k > 0)
                    b[7] = (k == len - 1) ? ($urandom_range(0, 99) < 15)
                                          : ($urandom_range(0, 99) < 40);
                el.push_back(b);
            end
        end else if (sel < 84) begin
            b = 8'($urandom_range(0, 255));
            el.push_back({b[7:5], 5'h1F});
        end else if (sel < 90) begin
            k = $urandom_range(0, 123);
            el.push_back(tag);
            el.push_back((k == 0) ? 8'h80 : 8'(8'h84 + k));
        end else if (sel < 95) begin
            // length far too long to send: abandon it with a restart
            el.push_back(tag);
            el.push_back(8'h84);
            el.push_back(8'($urandom_range(1, 255)));
            for (k = 0; k < 3; k++)
                el.push_back(8'($urandom_range(0, 255)));
            nlen = $urandom_range(0, 3);
            for (k = 0; k < nlen; k++)
                el.push_back(8'($urandom_range(0, 255)));
            restart_next = 1;
        end else begin
            nlen = $urandom_range(1, 4);
            for (k = 0; k < nlen; k++)
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 30);
            restart_next = 1;
            return;
        end
        keep = el.size();
        if (well_formed && keep > 2 && $urandom_range(0, 99) < 7) begin
            keep = $urandom_range(1, keep - 1);
            restart_next = 1;
        end
        for (k = 0; k < keep; k++)
            push_byte(el[k], (k == 0) ? first_restart : 1'b0);
    endtask

    task automatic put_byte(input stim_t item);
        s_valid <= 1'b1;
        s_in_byte <= item.data;
        s_restart <= item.restart;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (item.restart)
            restarts_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_pause();
        s_valid <= 1'b0;
        @(negedge aclk);
        wait (pending == 0);
        @(negedge aclk);
    endtask

    initial begin : stimulus
        int i, burst_left, gap, mid_point;
        for (i = 0; i < N_DIRECTED; i++)
            push_byte(DIRECTED[i], i == DIRECTED_RESTART_AT);
        while (byte_stream.size() < N_BYTES)
            gen_element();
        mid_point = N_DIRECTED + (byte_stream.size() - N_DIRECTED) / 2;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        burst_left = $urandom_range(1, 24);
        for (i = 0; i < byte_stream.size(); i++) begin
            if (i == N_DIRECTED || i == mid_point)
                drain_pause();
            put_byte(byte_stream[i]);
            burst_left = burst_left - 1;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
        end
        s_valid <= 1'b0;

        wait (pending == 0);
        repeat (10) @(posedge aclk);
        $display("Streamed %0d bytes (%0d flagged restart), checked %0d results, %0d errors",
                 bytes_sent, restarts_sent, results_checked, error_results);
        $display("Traffic: sender bursts and gaps, drained pauses, receiver stalls incl. %0d-cycle hold",
                 LONG_HOLD);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin : result_sink
        int seg, mode, k;
        bit long_hold_done;
        long_hold_done = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            seg = $urandom_range(10, 60);
            mode = $urandom_range(0, 3);
            for (k = 0; k < seg; k++) begin
                // hold off long enough for the output queue to back up into s_ready
                if (!long_hold_done && bytes_sent >= 150) begin
                    long_hold_done = 1;
                    m_ready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge aclk);
                end
                case (mode)
                    0, 1: m_ready <= 1'b1;
                    2: m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
                @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
